[design/integer_calculator_alu_unit_defines.svh]
// assertion macros for the integer calculator alu checker
// no dependencies; included by the checker file only
`ifndef INTEGER_CALCULATOR_ALU_UNIT_DEFINES_SVH
`define INTEGER_CALCULATOR_ALU_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define ICALC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is held
`define ICALC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/icalc_pkg.sv]
// shared types and constants for the integer calculator alu
// no dependencies; used by the top level, the checker and the testbench
`timescale 1ns / 1ps

package icalc_pkg;

  // result width default and fixed field widths
  localparam int DATA_WIDTH_DEF = 32;
  localparam int OP_WIDTH       = 31;
  localparam int RES_WIDTH      = 32;
  localparam int CMD_WIDTH      = 3;

  // iteration counts of the divider and root loops
  localparam int DIV_STEPS  = 31;
  localparam int ROOT_STEPS = 16;
  localparam int CNT_WIDTH  = 5;

  // operation codes
  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_SQRT = 3'd4,
    CMD_POW  = 3'd5
  } cmd_e_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDSUB,
    ST_MUL,
    ST_DIV,
    ST_SQRT,
    ST_PSTEP,
    ST_PACC,
    ST_PSQR
  } state_t;

  // input item
  typedef struct packed {
    logic [CMD_WIDTH-1:0] cmd;
    logic [OP_WIDTH-1:0]  operand_a;
    logic [OP_WIDTH-1:0]  operand_b;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [RES_WIDTH-1:0] result_value;
    logic                        divide_by_zero;
  } out_item_t;

endpackage

[design/icalc_addsub.sv]
// shared adder/subtractor of the calculator, with carry out as compare result
// depends on nothing but its width parameter
`timescale 1ns / 1ps

module icalc_addsub #(
  parameter int WIDTH = 34
) (
  input  logic [WIDTH-1:0] op_a,
  input  logic [WIDTH-1:0] op_b,
  input  logic             sub,
  output logic [WIDTH-1:0] sum,
  output logic             carry
);

  logic [WIDTH:0] full;
  logic [WIDTH-1:0] op_b_eff;

  // subtract as a plus inverted b plus one; carry set means a >= b
  assign op_b_eff = sub ? ~op_b : op_b;
  assign full     = {1'b0, op_a} + {1'b0, op_b_eff} + {{WIDTH{1'b0}}, sub};
  assign sum      = full[WIDTH-1:0];
  assign carry    = full[WIDTH];

endmodule

[design/integer_calculator_alu_unit.sv]
// Iterative integer calculator: add, subtract, multiply, divide, floor root, power.
// Channels: start/busy command input carrying in_item, one-cycle out_valid strobe with
// out_item. An item is taken when start is high and busy is low; it gives one result.
// All arithmetic runs through one shared adder/subtractor under a small sequencer, one
// step per cycle, so the work per item depends on the operation:
//   add, subtract            direct sum or difference
//   multiply                 shift-add, ends when multiplier empties
//   divide                   one quotient bit per cycle; zero divisor strobes from idle with the flag set
//   square root              two radicand bits per cycle
//   power                    square-and-multiply on the shift-add multiplier
//   unused codes             give zero, strobed from idle
// Busy stays high until the result strobes, so items are worked one at a time.
// Results wrap modulo 2^DATA_WIDTH and are sign-extended or cut to 32 bits.
// Reset (rst_n low, synchronous) returns to idle and drops the strobe. The receiver
// cannot stall: each result is shown for exactly one cycle.
// Depends on icalc_pkg and icalc_addsub.
`timescale 1ns / 1ps

module integer_calculator_alu_unit #(
  parameter int DATA_WIDTH = icalc_pkg::DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  icalc_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output icalc_pkg::out_item_t out_item
);

  localparam int UW = (DATA_WIDTH > 34) ? DATA_WIDTH : 34;
  localparam int OPW = icalc_pkg::OP_WIDTH;
  localparam int CW = icalc_pkg::CNT_WIDTH;
  localparam logic [64:0] ONE65 = 65'd1;
  localparam logic [UW-1:0] DMASK = UW'((ONE65 << DATA_WIDTH) - ONE65);

  icalc_pkg::state_t state_r, state_nxt;
  logic [icalc_pkg::CMD_WIDTH-1:0] cmd_r, cmd_nxt;
  logic [UW-1:0] w0_r, w0_nxt;
  logic [UW-1:0] w1_r, w1_nxt;
  logic [UW-1:0] w2_r, w2_nxt;
  logic [UW-1:0] acc_r, acc_nxt;
  logic [UW-1:0] base_r, base_nxt;
  logic [OPW-1:0] exp_r, exp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] res_r, res_nxt;
  logic dz_r, dz_nxt;
  logic out_valid_r, out_valid_nxt;

  logic accept;
  logic [UW-1:0] u_a, u_b, u_sum;
  logic u_sub, u_carry;
  logic [UW-1:0] div_rem_sh, sq_rem_sh, sq_trial, sq_root_new;
  logic [OPW-1:0] div_q_new;
  logic mul_done;

  assign busy   = (state_r != icalc_pkg::ST_IDLE);
  assign accept = start && !busy;

  // step values of the divider and root loops, and the multiplier end test
  assign div_rem_sh  = {w0_r[UW-2:0], w2_r[OPW-1]};
  assign div_q_new   = {w2_r[OPW-2:0], u_carry};
  assign sq_rem_sh   = {w0_r[UW-3:0], w2_r[31:30]};
  assign sq_trial    = {w1_r[UW-3:0], 2'b01};
  assign sq_root_new = {w1_r[UW-2:0], u_carry};
  assign mul_done    = (w2_r == '0);

  // operand selection for the shared unit
  always_comb begin
    u_a   = '0;
    u_b   = '0;
    u_sub = 1'b0;
    unique case (state_r)
      icalc_pkg::ST_ADDSUB: begin
        u_a   = w0_r;
        u_b   = w1_r;
        u_sub = (cmd_r == icalc_pkg::CMD_SUB);
      end
      icalc_pkg::ST_MUL, icalc_pkg::ST_PACC, icalc_pkg::ST_PSQR: begin
        u_a = w0_r;
        u_b = w1_r;
      end
      icalc_pkg::ST_DIV: begin
        u_a   = div_rem_sh;
        u_b   = w1_r;
        u_sub = 1'b1;
      end
      icalc_pkg::ST_SQRT: begin
        u_a   = sq_rem_sh;
        u_b   = sq_trial;
        u_sub = 1'b1;
      end
      default: begin
        u_a = '0;
      end
    endcase
  end

  icalc_addsub #(
    .WIDTH(UW)
  ) u_addsub (
    .op_a (u_a),
    .op_b (u_b),
    .sub  (u_sub),
    .sum  (u_sum),
    .carry(u_carry)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      icalc_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (icalc_pkg::cmd_e_t'(in_item.cmd))
            icalc_pkg::CMD_ADD, icalc_pkg::CMD_SUB: state_nxt = icalc_pkg::ST_ADDSUB;
            icalc_pkg::CMD_MUL:  state_nxt = icalc_pkg::ST_MUL;
            icalc_pkg::CMD_DIV:  state_nxt = (in_item.operand_b == '0) ?
                                             icalc_pkg::ST_IDLE : icalc_pkg::ST_DIV;
            icalc_pkg::CMD_SQRT: state_nxt = icalc_pkg::ST_SQRT;
            icalc_pkg::CMD_POW:  state_nxt = icalc_pkg::ST_PSTEP;
            default:             state_nxt = icalc_pkg::ST_IDLE;
          endcase
        end
      end
      icalc_pkg::ST_ADDSUB: state_nxt = icalc_pkg::ST_IDLE;
      icalc_pkg::ST_MUL: begin
        if (mul_done) state_nxt = icalc_pkg::ST_IDLE;
      end
      icalc_pkg::ST_DIV, icalc_pkg::ST_SQRT: begin
        if (cnt_r == '0) state_nxt = icalc_pkg::ST_IDLE;
      end
      icalc_pkg::ST_PSTEP: begin
        if (exp_r == '0)      state_nxt = icalc_pkg::ST_IDLE;
        else if (exp_r[0])    state_nxt = icalc_pkg::ST_PACC;
        else                  state_nxt = icalc_pkg::ST_PSQR;
      end
      icalc_pkg::ST_PACC, icalc_pkg::ST_PSQR: begin
        if (mul_done) state_nxt = icalc_pkg::ST_PSTEP;
      end
      default: state_nxt = icalc_pkg::ST_IDLE;
    endcase
  end

  // datapath and result updates
  always_comb begin
    cmd_nxt       = cmd_r;
    w0_nxt        = w0_r;
    w1_nxt        = w1_r;
    w2_nxt        = w2_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    dz_nxt        = dz_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      icalc_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_nxt = in_item.cmd;
          dz_nxt  = 1'b0;
          unique case (icalc_pkg::cmd_e_t'(in_item.cmd))
            icalc_pkg::CMD_ADD, icalc_pkg::CMD_SUB: begin
              w0_nxt = UW'(in_item.operand_a);
              w1_nxt = UW'(in_item.operand_b);
            end
            icalc_pkg::CMD_MUL: begin
              w0_nxt = '0;
              w1_nxt = UW'(in_item.operand_a) & DMASK;
              w2_nxt = UW'(in_item.operand_b) & DMASK;
            end
            icalc_pkg::CMD_DIV: begin
              if (in_item.operand_b == '0) begin
                res_nxt       = '0;
                dz_nxt        = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                w0_nxt  = '0;
                w1_nxt  = UW'(in_item.operand_b);
                w2_nxt  = UW'(in_item.operand_a);
                cnt_nxt = CW'(icalc_pkg::DIV_STEPS - 1);
              end
            end
            icalc_pkg::CMD_SQRT: begin
              w0_nxt  = '0;
              w1_nxt  = '0;
              w2_nxt  = UW'(in_item.operand_a);
              cnt_nxt = CW'(icalc_pkg::ROOT_STEPS - 1);
            end
            icalc_pkg::CMD_POW: begin
              acc_nxt  = UW'(1);
              base_nxt = UW'(in_item.operand_a) & DMASK;
              exp_nxt  = in_item.operand_b;
            end
            default: begin
              res_nxt       = '0;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      icalc_pkg::ST_ADDSUB: begin
        res_nxt       = u_sum[DATA_WIDTH-1:0];
        out_valid_nxt = 1'b1;
      end
      icalc_pkg::ST_MUL, icalc_pkg::ST_PACC, icalc_pkg::ST_PSQR: begin
        if (mul_done) begin
          if (state_r == icalc_pkg::ST_MUL) begin
            res_nxt       = w0_r[DATA_WIDTH-1:0];
            out_valid_nxt = 1'b1;
          end else if (state_r == icalc_pkg::ST_PACC) begin
            acc_nxt = w0_r;
          end else begin
            base_nxt = w0_r;
          end
        end else begin
          // shift-add step: add multiplicand when the low multiplier bit is set
          if (w2_r[0]) w0_nxt = u_sum & DMASK;
          w1_nxt = (w1_r << 1) & DMASK;
          w2_nxt = w2_r >> 1;
        end
      end
      icalc_pkg::ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        w0_nxt  = u_carry ? u_sum : div_rem_sh;
        w2_nxt  = UW'(div_q_new);
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          res_nxt       = DATA_WIDTH'(div_q_new);
          out_valid_nxt = 1'b1;
        end
      end
      icalc_pkg::ST_SQRT: begin
        // digit-by-digit root, two radicand bits per cycle
        w0_nxt  = u_carry ? u_sum : sq_rem_sh;
        w1_nxt  = sq_root_new;
        w2_nxt  = {w2_r[UW-3:0], 2'b00};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          res_nxt       = DATA_WIDTH'(sq_root_new);
          out_valid_nxt = 1'b1;
        end
      end
      icalc_pkg::ST_PSTEP: begin
        // square-and-multiply: result on zero exponent, fold base into acc if odd, else square base
        if (exp_r == '0) begin
          res_nxt       = acc_r[DATA_WIDTH-1:0];
          out_valid_nxt = 1'b1;
        end else if (exp_r[0]) begin
          w0_nxt  = '0;
          w1_nxt  = base_r;
          w2_nxt  = acc_r;
          exp_nxt = {exp_r[OPW-1:1], 1'b0};
        end else begin
          w0_nxt  = '0;
          w1_nxt  = base_r;
          w2_nxt  = base_r;
          exp_nxt = exp_r >> 1;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= icalc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    w0_r   <= w0_nxt;
    w1_r   <= w1_nxt;
    w2_r   <= w2_nxt;
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
    dz_r   <= dz_nxt;
  end

  // result item: sign-extend or cut the wrapped value to the field width
  assign out_valid               = out_valid_r;
  assign out_item.result_value   = icalc_pkg::RES_WIDTH'($signed(res_r));
  assign out_item.divide_by_zero = dz_r;

endmodule

[design/icalc_checker.sv]
// port-level checks for the integer calculator alu, bound to the top level
// depends on icalc_pkg and integer_calculator_alu_unit_defines.svh
`timescale 1ns / 1ps
`include "integer_calculator_alu_unit_defines.svh"

module icalc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input icalc_pkg::in_item_t  in_item,
  input logic                 out_valid,
  input icalc_pkg::out_item_t out_item
);

  // an accepted item either starts work or strobes its result at once
  `ICALC_ASSERT_NEXT(a_accept_acts, clk, rst_n, start && !busy, busy || out_valid, "accepted item ignored")

  // results only show while the block is idle
  `ICALC_ASSERT_NOW(a_out_idle, clk, rst_n, out_valid, !busy, "result strobed while busy")

  // leaving busy always delivers a result
  `ICALC_ASSERT_NOW(a_busy_end, clk, rst_n, $fell(busy) && $past(rst_n), out_valid, "busy dropped without result")

  // divide-by-zero flag comes right after an item with a zero divisor
  `ICALC_ASSERT_NOW(a_dz_src, clk, rst_n, out_valid && out_item.divide_by_zero, $past(start && !busy) && ($past(in_item.operand_b) == 0) && (out_item.result_value == 0), "bad divide-by-zero result")

endmodule

bind integer_calculator_alu_unit icalc_checker u_icalc_checker (.*);

[tb/sv/testbench.sv]
// self-checking testbench for the iterative integer calculator alu
// depends on icalc_pkg and the integer_calculator_alu_unit rtl
`timescale 1ns / 1ps

module testbench;

  // block width and run limits
  localparam int DW = icalc_pkg::DATA_WIDTH_DEF;
  localparam int OPW = icalc_pkg::OP_WIDTH;
  localparam int CMDW = icalc_pkg::CMD_WIDTH;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 700;
  localparam logic [OPW-1:0] OP_MAX = {OPW{1'b1}};

  // codes outside the operation set
  localparam logic [CMDW-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMDW-1:0] CMD_RSVD7 = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  icalc_pkg::in_item_t  in_item = '0;
  logic                 busy;
  logic                 out_valid;
  icalc_pkg::out_item_t out_item;

  // expected results in issue order, plus bookkeeping
  icalc_pkg::out_item_t pending_results[$];
  icalc_pkg::out_item_t want_item;
  bit        allow_idle = 1'b1;
  int        fail_count = 0;
  int        cycle_count = 0;
  int        op_count[8];
  int        div_zero_seen = 0;
  int        negative_seen = 0;

  integer_calculator_alu_unit #(.DATA_WIDTH(DW)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("integer_calculator_alu_unit regression: fail");
      $finish;
    end
  end

  // expected result of one item, wrapped to the block width then fit to 32 bits
  function automatic icalc_pkg::out_item_t alu_predict(icalc_pkg::in_item_t it);
    logic [63:0] a, b, r, base, ex, mask, root, trial;
    icalc_pkg::out_item_t res;
    a = 64'(it.operand_a);
    b = 64'(it.operand_b);
    r = '0;
    res = '0;
    mask = (DW >= 64) ? '1 : ((64'd1 << DW) - 64'd1);
    case (it.cmd)
      icalc_pkg::CMD_ADD: r = a + b;
      icalc_pkg::CMD_SUB: r = a - b;
      icalc_pkg::CMD_MUL: r = a * b;
      icalc_pkg::CMD_DIV: begin
        if (b == 0) res.divide_by_zero = 1'b1;
        else r = a / b;
      end
      // largest root whose square stays within the radicand, one bit at a time
      icalc_pkg::CMD_SQRT: begin
        root = '0;
        for (int i = 15; i >= 0; i--) begin
          trial = root | (64'd1 << i);
          if (trial * trial <= a) root = trial;
        end
        r = root;
      end
      // square and multiply, wrapping at 64 bits
      icalc_pkg::CMD_POW: begin
        r = 64'd1;
        base = a;
        ex = b;
        while (ex != 0) begin
          if (ex[0]) r = r * base;
          base = base * base;
          ex = ex >> 1;
        end
      end
      default: r = '0;
    endcase
    r = r & mask;
    if (r[DW-1]) r = r | ~mask;
    res.result_value = r[icalc_pkg::RES_WIDTH-1:0];
    return res;
  endfunction

  // operand spread over the corners and the body of the range
  function automatic logic [OPW-1:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return OPW'($urandom_range(0, 15));
      1: return OP_MAX - OPW'($urandom_range(0, 15));
      2: return OPW'(32'd1 << $urandom_range(0, OPW - 1));
      default: return OPW'($urandom);
    endcase
  endfunction

  // failure report, only the first ten in full
  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  // send one item, holding start until the block takes it
  task automatic issue_cmd(input logic [CMDW-1:0] cmd,
                           input logic [OPW-1:0] a,
                           input logic [OPW-1:0] b);
    icalc_pkg::in_item_t it;
    bit took;
    it.cmd = cmd;
    it.operand_a = a;
    it.operand_b = b;
    took = 1'b0;
    while (allow_idle && $urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      in_item <= {CMDW'($urandom), OPW'($urandom), OPW'($urandom)};
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    // busy is read mid-cycle so it is the value the coming edge sees
    while (!took) begin
      @(negedge clk);
      took = (busy === 1'b0);
      @(posedge clk);
    end
    pending_results.push_back(alu_predict(it));
    op_count[cmd]++;
  endtask

  // compare each strobed result with the oldest expectation, sampled mid-cycle
  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result value=%0d div0=%b",
                               out_item.result_value, out_item.divide_by_zero));
      end else begin
        want_item = pending_results.pop_front();
        if (out_item.result_value !== want_item.result_value ||
            out_item.divide_by_zero !== want_item.divide_by_zero)
          note_failure($sformatf("mismatch: expected value=%0d div0=%b, got value=%0d div0=%b",
                                 want_item.result_value, want_item.divide_by_zero,
                                 out_item.result_value, out_item.divide_by_zero));
        if (want_item.divide_by_zero) div_zero_seen++;
        if (want_item.result_value < 0) negative_seen++;
      end
    end
  end

  // add and subtract wrap, multiply overflow
  task automatic test_add_sub_mul();
    issue_cmd(icalc_pkg::CMD_ADD, OP_MAX, OP_MAX);
    issue_cmd(icalc_pkg::CMD_ADD, '0, '0);
    issue_cmd(icalc_pkg::CMD_SUB, '0, OP_MAX);
    issue_cmd(icalc_pkg::CMD_SUB, OP_MAX, '0);
    issue_cmd(icalc_pkg::CMD_MUL, OP_MAX, OP_MAX);
    issue_cmd(icalc_pkg::CMD_MUL, '0, OP_MAX);
    issue_cmd(icalc_pkg::CMD_MUL, 31'd1, OP_MAX);
  endtask

  // quotient extremes and zero divisor
  task automatic test_divide();
    issue_cmd(icalc_pkg::CMD_DIV, OP_MAX, 31'd1);
    issue_cmd(icalc_pkg::CMD_DIV, 31'd7, '0);
    issue_cmd(icalc_pkg::CMD_DIV, '0, '0);
    issue_cmd(icalc_pkg::CMD_DIV, 31'd5, OP_MAX);
    issue_cmd(icalc_pkg::CMD_DIV, OP_MAX, OP_MAX);
  endtask

  // roots of zero, one, the largest radicand and around a perfect square
  task automatic test_square_root();
    issue_cmd(icalc_pkg::CMD_SQRT, '0, pick_operand());
    issue_cmd(icalc_pkg::CMD_SQRT, 31'd1, OP_MAX);
    issue_cmd(icalc_pkg::CMD_SQRT, OP_MAX, pick_operand());
    issue_cmd(icalc_pkg::CMD_SQRT, 31'd2147395600, '0);
    issue_cmd(icalc_pkg::CMD_SQRT, 31'd2147395599, pick_operand());
  endtask

  // zero exponent, zero base, sign-bit wrap and a full-width exponent
  task automatic test_power();
    issue_cmd(icalc_pkg::CMD_POW, '0, '0);
    issue_cmd(icalc_pkg::CMD_POW, 31'd5, '0);
    issue_cmd(icalc_pkg::CMD_POW, '0, 31'd5);
    issue_cmd(icalc_pkg::CMD_POW, OP_MAX, OP_MAX);
    issue_cmd(icalc_pkg::CMD_POW, 31'd2, 31'd31);
    issue_cmd(icalc_pkg::CMD_POW, 31'd3, 31'd20);
  endtask

  // undefined codes give zero with no flag
  task automatic test_unused_codes();
    issue_cmd(CMD_RSVD6, pick_operand(), pick_operand());
    issue_cmd(CMD_RSVD7, OP_MAX, OP_MAX);
  endtask

  // random mix; exponents mostly short so power stays quick
  task automatic test_random_mix();
    logic [CMDW-1:0] cmd;
    logic [OPW-1:0]  a, b;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      allow_idle = !(n >= 250 && n < 420);
      if ($urandom_range(0, 99) < 4)
        cmd = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
      else
        cmd = CMDW'($urandom_range(int'(icalc_pkg::CMD_ADD), int'(icalc_pkg::CMD_POW)));
      a = pick_operand();
      b = pick_operand();
      case (cmd)
        icalc_pkg::CMD_DIV: if ($urandom_range(0, 7) == 0) b = '0;
        icalc_pkg::CMD_POW: begin
          if ($urandom_range(0, 1)) a = OPW'($urandom_range(0, 20));
          if ($urandom_range(0, 11) != 0) b = OPW'($urandom_range(0, 40));
        end
        default: ;
      endcase
      issue_cmd(cmd, a, b);
    end
    allow_idle = 1'b1;
  endtask

  // reset, tests in turn, drain and verdict
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_add_sub_mul();
    test_divide();
    test_square_root();
    test_power();
    test_unused_codes();
    test_random_mix();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("items: add %0d, sub %0d, mul %0d, div %0d, sqrt %0d, pow %0d, unused %0d",
             op_count[icalc_pkg::CMD_ADD], op_count[icalc_pkg::CMD_SUB],
             op_count[icalc_pkg::CMD_MUL], op_count[icalc_pkg::CMD_DIV],
             op_count[icalc_pkg::CMD_SQRT], op_count[icalc_pkg::CMD_POW],
             op_count[CMD_RSVD6] + op_count[CMD_RSVD7]);
    $display("zero-divisor results %0d, negative results %0d, failures %0d",
             div_zero_seen, negative_seen, fail_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("integer_calculator_alu_unit regression: pass");
    end else begin
      $display("integer_calculator_alu_unit regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/icalc_pkg.sv
design/icalc_addsub.sv
design/integer_calculator_alu_unit.sv
design/icalc_checker.sv
tb/sv/testbench.sv
